@@ sv/sdsr_pkg.sv @@
`default_nettype none

package sdsr_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    ACT_PUSH = 3'd0,
    ACT_POP  = 3'd1,
    ACT_PEEK = 3'd2,
    ACT_DUP  = 3'd3,
    ACT_SWAP = 3'd4,
    ACT_ROLL = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // What every cell does with its value at each clock.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PUSH = 2'd1,  // take the neighbor above
    CELL_POP  = 2'd2,  // take the neighbor below
    CELL_ROLL = 2'd3   // above the target take from below, at the target take the top
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ sv/stack_with_dup_swap_roll.sv @@
// LIFO stack of STACK_DEPTH entries held in a row of register cells, cell 0
// being the top. A successful push, pop, duplicate, swap or roll updates
// all cells at once while peek leaves them held, so an item is taken on any
// cycle where start is high; busy is never raised. The result appears with
// done in the cycle after the item is taken and is shown for that one
// cycle only, so capture it then. Entries below the depth are never shown.
`default_nettype none

module stack_with_dup_swap_roll #(
  parameter int STACK_DEPTH = sdsr_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = sdsr_pkg::VALUE_WIDTH_DEF,
  localparam int CNT_W      = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [2:0]             action,
  input  wire logic [VALUE_WIDTH-1:0] push_value,
  input  wire logic [CNT_W-1:0]       roll_position,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [VALUE_WIDTH-1:0]      top_value,
  output logic [CNT_W-1:0]            entry_count,
  output logic                        is_empty
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO      = CNT_W'(2);

  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [VALUE_WIDTH-1:0] cell_val [STACK_DEPTH];
  logic [VALUE_WIDTH-1:0] up_in;
  logic [CNT_W-1:0]       roll_last;
  sdsr_pkg::cell_cmd_t    cmd;
  sdsr_pkg::status_t      st;
  logic [VALUE_WIDTH-1:0] shown;
  logic [VALUE_WIDTH-1:0] top_or_zero;
  logic                   empty;
  logic                   full;
  logic                   take;

  assign busy        = 1'b0;
  assign take        = start && !busy;
  assign empty       = (count == '0);
  assign full        = (count == FULL_CNT);
  assign top_or_zero = empty ? '0 : cell_val[0];

  always_comb begin
    cmd.op     = sdsr_pkg::CELL_HOLD;
    up_in      = push_value;
    roll_last  = ONE;
    st         = sdsr_pkg::ST_OK;
    count_next = count;
    shown      = top_or_zero;
    case (sdsr_pkg::action_t'(action))
      sdsr_pkg::ACT_PUSH: begin
        if (full) begin
          st = sdsr_pkg::ST_FULL;
        end else begin
          cmd.op     = sdsr_pkg::CELL_PUSH;
          count_next = count + ONE;
          shown      = push_value;
        end
      end
      sdsr_pkg::ACT_POP: begin
        if (empty) begin
          st = sdsr_pkg::ST_FEW;
        end else begin
          cmd.op     = sdsr_pkg::CELL_POP;
          count_next = count - ONE;
          shown      = cell_val[0];
        end
      end
      sdsr_pkg::ACT_PEEK: begin
        if (empty) begin
          st = sdsr_pkg::ST_FEW;
        end
      end
      sdsr_pkg::ACT_DUP: begin
        if (empty) begin
          st = sdsr_pkg::ST_FEW;
        end else if (full) begin
          st = sdsr_pkg::ST_FULL;
        end else begin
          // push a copy of the top into the chain
          cmd.op     = sdsr_pkg::CELL_PUSH;
          up_in      = cell_val[0];
          count_next = count + ONE;
        end
      end
      sdsr_pkg::ACT_SWAP: begin
        if (count < TWO) begin
          st = sdsr_pkg::ST_FEW;
        end else begin
          cmd.op    = sdsr_pkg::CELL_ROLL;
          roll_last = ONE;
          shown     = cell_val[1];
        end
      end
      sdsr_pkg::ACT_ROLL: begin
        if (roll_position <= ONE) begin
          st = sdsr_pkg::ST_OK;
        end else if (roll_position > count) begin
          st = sdsr_pkg::ST_FEW;
        end else begin
          cmd.op    = sdsr_pkg::CELL_ROLL;
          roll_last = roll_position - ONE;
          shown     = cell_val[1];
        end
      end
      default: st = sdsr_pkg::ST_OK;
    endcase
    if (!take) begin
      cmd.op = sdsr_pkg::CELL_HOLD;
    end
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] up_v;
    logic [VALUE_WIDTH-1:0] down_v;
    if (i == 0) begin : g_top
      assign up_v = up_in;
    end else begin : g_mid
      assign up_v = cell_val[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign down_v = '0;
    end else begin : g_inner
      assign down_v = cell_val[i+1];
    end
    sdsr_cell #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .roll_last (roll_last),
      .up_value  (up_v),
      .down_value(down_v),
      .top_in    (cell_val[0]),
      .value     (cell_val[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= take;
      if (take) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status      <= st;
      top_value   <= shown;
      entry_count <= count_next;
      is_empty    <= (count_next == '0);
    end
  end

endmodule

`default_nettype wire

@@ sv/sdsr_cell.sv @@
`default_nettype none

module sdsr_cell #(
  parameter int VALUE_WIDTH = sdsr_pkg::VALUE_WIDTH_DEF,
  parameter int CNT_W       = 7,
  parameter int IDX         = 0
) (
  input  wire logic                   clk,
  input  wire sdsr_pkg::cell_cmd_t    cmd,
  input  wire logic [CNT_W-1:0]       roll_last,
  input  wire logic [VALUE_WIDTH-1:0] up_value,
  input  wire logic [VALUE_WIDTH-1:0] down_value,
  input  wire logic [VALUE_WIDTH-1:0] top_in,
  output logic      [VALUE_WIDTH-1:0] value
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [VALUE_WIDTH-1:0] value_next;

  always_comb begin
    value_next = value;
    case (cmd.op)
      sdsr_pkg::CELL_PUSH: value_next = up_value;
      sdsr_pkg::CELL_POP:  value_next = down_value;
      sdsr_pkg::CELL_ROLL: begin
        // lift cells above the target, drop the old top into the target
        if (MY_IDX < roll_last) begin
          value_next = down_value;
        end else if (MY_IDX == roll_last) begin
          value_next = top_in;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

@@ sv/sdsr_chk.sv @@
`default_nettype none

module sdsr_chk #(
  parameter int STACK_DEPTH = sdsr_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = sdsr_pkg::VALUE_WIDTH_DEF,
  localparam int CNT_W      = $clog2(STACK_DEPTH + 1)
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic [2:0]             action,
  input wire logic [VALUE_WIDTH-1:0] push_value,
  input wire logic [CNT_W-1:0]       roll_position,
  input wire logic                   done,
  input wire logic [1:0]             status,
  input wire logic [VALUE_WIDTH-1:0] top_value,
  input wire logic [CNT_W-1:0]       entry_count,
  input wire logic                   is_empty
);

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    done == $past(start && !busy && !rst))
    else $error("result strobe does not match the taken item");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with depth");

  a_full_source: assert property (@(posedge clk) disable iff (rst)
    (done && status == sdsr_pkg::ST_FULL) |->
      ($past(action) == sdsr_pkg::ACT_PUSH || $past(action) == sdsr_pkg::ACT_DUP))
    else $error("full status from an item that cannot grow the stack");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && is_empty && $past(action) != sdsr_pkg::ACT_POP) |-> (top_value == '0))
    else $error("nonzero top shown on an empty stack");

endmodule

bind stack_with_dup_swap_roll sdsr_chk #(
  .STACK_DEPTH(STACK_DEPTH),
  .VALUE_WIDTH(VALUE_WIDTH)
) u_sdsr_chk (.*);

`default_nettype wire
